// File: hdl/pointer_accel_gain_assert.svh
// Assertion macros shared by the pointer acceleration RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POINTER_ACCEL_GAIN_ASSERT_SVH
`define POINTER_ACCEL_GAIN_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PAG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pag: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PAG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pag: next-cycle check failed");
`else
`define PAG_ASSERT_IMP(lbl, ante, cons)
`define PAG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/pag_pkg.sv
// Shared types, constants and curve tables for the pointer acceleration block.
// No dependencies; every RTL module imports this package.
package pag_pkg;

  // Parameter defaults
  localparam int DELTA_FRAC_BITS_DEF = 4;
  localparam int COEF_FRAC_BITS_DEF  = 16;

  // Field widths
  localparam int DELTA_W = 16;
  localparam int OUT_W   = 20;
  localparam int SUM_W   = DELTA_W + 1;
  localparam int LVL_W   = 4;
  localparam int SEG_W   = 2;

  // Curve table geometry
  localparam int NUM_LEVELS = 11;
  localparam int NUM_SEGS   = 3;
  localparam int TAB_N      = NUM_LEVELS * NUM_SEGS;
  localparam int TAB_IW     = $clog2(TAB_N);
  localparam int BREAK_LOW  = 8;
  localparam int BREAK_MID  = 32;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_SET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_SPEED = 2'd2;

  localparam logic [LVL_W-1:0] USER_SPEED_RST = 4'd5;
  localparam logic [LVL_W-1:0] LEVEL_MIN      = 4'd1;
  localparam logic [LVL_W-1:0] LEVEL_MAX      = 4'd11;

  // Segment codes
  localparam logic [SEG_W-1:0] SEG_LOW  = 2'd0;
  localparam logic [SEG_W-1:0] SEG_MID  = 2'd1;
  localparam logic [SEG_W-1:0] SEG_HIGH = 2'd2;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ZERO = 1'b1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Slopes and offsets in hundredths, level-major, three segments each
  localparam int SLOPE_H [TAB_N] = '{
    16, 30, 56,    32, 60, 112,   48, 90, 168,   64, 120, 224,
    80, 150, 280,  86, 195, 364,  92, 240, 448,  98, 285, 532,
    104, 330, 616, 110, 375, 700, 116, 420, 784
  };
  localparam int OFFSET_H [TAB_N] = '{
    0, -112, -944,    0, -224, -1888,   0, -336, -2832,
    0, -448, -3776,   0, -560, -4720,   0, -872, -6280,
    0, -1184, -7840,  0, -1496, -9400,  0, -1808, -10960,
    0, -2120, -12520, 0, -2432, -14080
  };

  // Input and result words
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
  } pag_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] accel_x;
    logic signed [OUT_W-1:0] accel_y;
    logic                    status;
  } pag_out_t;

  // Classified command handed from front end to back end
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [SUM_W-1:0]          sum;
    logic [TAB_IW-1:0]         tab_idx;
    logic                      zero;
  } pag_cmd_t;

  // Hundredths to fixed point, round to nearest, ties away from zero.
  // Only evaluated at elaboration.
  function automatic longint coef_q(input int hundredths, input int frac_bits);
    longint mag;
    longint q;
    mag = (hundredths < 0) ? -longint'(hundredths) : longint'(hundredths);
    q   = (mag * (longint'(1) <<< frac_bits) + 50) / 100;
    return (hundredths < 0) ? -q : q;
  endfunction

endpackage

// File: hdl/pag_front.sv
// Front end: configuration registers, speed level and segment classification.
// Depends on pag_pkg.
module pag_front import pag_pkg::*; #(
  parameter int DELTA_FRAC_BITS = DELTA_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  pag_in_t              in_data,
  output pag_cmd_t             cmd
);

  localparam logic [SUM_W-1:0] THR_LOW = SUM_W'(BREAK_LOW << (DELTA_FRAC_BITS + 1));
  localparam logic [SUM_W-1:0] THR_MID = SUM_W'(BREAK_MID << (DELTA_FRAC_BITS + 1));

  logic [LVL_W-1:0]   user_speed_r;
  logic               user_set_r;
  logic [LVL_W-1:0]   vendor_speed_r;
  logic [DELTA_W-1:0] abs_x;
  logic [DELTA_W-1:0] abs_y;
  logic [SUM_W-1:0]   sum;
  logic [LVL_W-1:0]   sel;
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   lvl_off;
  logic [SEG_W-1:0]   seg;

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_speed_r   <= USER_SPEED_RST;
      user_set_r     <= 1'b0;
      vendor_speed_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_USER_SPEED:   user_speed_r   <= cfg_data;
        CFG_USER_SET:     user_set_r     <= cfg_data[0];
        CFG_VENDOR_SPEED: vendor_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Motion magnitude, twice the mean speed in raw units
  assign abs_x = in_data.delta_x[DELTA_W-1] ? DELTA_W'(-in_data.delta_x)
                                             : DELTA_W'(in_data.delta_x);
  assign abs_y = in_data.delta_y[DELTA_W-1] ? DELTA_W'(-in_data.delta_y)
                                             : DELTA_W'(in_data.delta_y);
  assign sum   = {1'b0, abs_x} + {1'b0, abs_y};

  // Speed level pick and clamp
  always_comb begin
    sel = (user_set_r || vendor_speed_r == '0) ? user_speed_r : vendor_speed_r;
    if (sel < LEVEL_MIN) begin
      lvl = LEVEL_MIN;
    end else if (sel > LEVEL_MAX) begin
      lvl = LEVEL_MAX;
    end else begin
      lvl = sel;
    end
  end

  // Segment by breakpoint
  always_comb begin
    if (sum <= THR_LOW) begin
      seg = SEG_LOW;
    end else if (sum <= THR_MID) begin
      seg = SEG_MID;
    end else begin
      seg = SEG_HIGH;
    end
  end

  assign lvl_off = lvl - LEVEL_MIN;

  always_comb begin
    cmd.dx      = in_data.delta_x;
    cmd.dy      = in_data.delta_y;
    cmd.sum     = sum;
    cmd.tab_idx = TAB_IW'(lvl_off) * TAB_IW'(NUM_SEGS) + TAB_IW'(seg);
    cmd.zero    = (sum == '0);
  end

endmodule

// File: hdl/pag_queue.sv
// Short command queue between the front end and the back end.
// Depends on pag_pkg and pointer_accel_gain_assert.svh.
`include "pointer_accel_gain_assert.svh"

module pag_queue import pag_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pag_cmd_t push_cmd,
  output logic     full,
  output logic     pop,
  output pag_cmd_t pop_cmd
);

  pag_cmd_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  // Back end never stalls, so a word leaves whenever one is held
  assign pop     = (count_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `PAG_ASSERT_IMP(a_cnt_bound, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH))
  `PAG_ASSERT_NXT(a_drain, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

// File: hdl/pag_back.sv
// Back end: gain arithmetic pipeline with a one-bit-per-stage restoring divider.
// Depends on pag_pkg and pointer_accel_gain_assert.svh.
`include "pointer_accel_gain_assert.svh"

module pag_back import pag_pkg::*; #(
  parameter int DELTA_FRAC_BITS = DELTA_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  pag_cmd_t in_cmd,
  output logic     out_valid,
  output pag_out_t out_data
);

  localparam int SW    = COEF_FRAC_BITS + 3;       // slope, unsigned
  localparam int OW    = COEF_FRAC_BITS + 9;       // offset, signed
  localparam int PW    = SW + SUM_W;               // slope * sum
  localparam int NUM_W = COEF_FRAC_BITS + 22;      // gain numerator, signed
  localparam int MAG_W = NUM_W - 1;
  localparam int LO_W  = 24;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int AD_W  = DELTA_W;
  localparam int P_W   = AD_W + MAG_W;
  localparam int MW    = P_W - COEF_FRAC_BITS;     // dividend after dropping fraction
  localparam int QW    = OUT_W;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             neg_x;
    logic             neg_y;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic [MW-1:0]    rem_x;
    logic [MW-1:0]    rem_y;
    logic [QW-1:0]    q_x;
    logic [QW-1:0]    q_y;
    logic [SUM_W-1:0] sum;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             zero;
  } div_t;

  // Curve constants, built at elaboration
  logic [SW-1:0]        slope_tab [TAB_N];
  logic signed [OW-1:0] off_tab   [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    localparam longint SQ = coef_q(SLOPE_H[i], COEF_FRAC_BITS);
    localparam longint OQ = coef_q(OFFSET_H[i], COEF_FRAC_BITS);
    assign slope_tab[i] = SW'(SQ);
    assign off_tab[i]   = OW'(OQ);
  end

  // Stage 0: table lookup and slope * sum
  logic                 s0_vld_r;
  logic [PW-1:0]        s0_prod_r;
  logic signed [OW-1:0] s0_off_r;
  pag_cmd_t             s0_cmd_r;
  logic [PW-1:0]        prod;

  assign prod = slope_tab[in_cmd.tab_idx] * in_cmd.sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_prod_r <= prod;
    s0_off_r  <= off_tab[in_cmd.tab_idx];
    s0_cmd_r  <= in_cmd;
  end

  // Stage 1: numerator, magnitudes and result signs
  logic                    s1_vld_r;
  logic [MAG_W-1:0]        s1_num_r;
  logic [AD_W-1:0]         s1_ax_r;
  logic [AD_W-1:0]         s1_ay_r;
  side_t                   s1_side_r;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_abs;

  assign num = $signed({2'b00, s0_prod_r})
             + (NUM_W'(s0_off_r) <<< (DELTA_FRAC_BITS + 1));
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r        <= num_abs[MAG_W-1:0];
    s1_ax_r         <= s0_cmd_r.dx[DELTA_W-1] ? AD_W'(-s0_cmd_r.dx) : AD_W'(s0_cmd_r.dx);
    s1_ay_r         <= s0_cmd_r.dy[DELTA_W-1] ? AD_W'(-s0_cmd_r.dy) : AD_W'(s0_cmd_r.dy);
    s1_side_r.sum   <= s0_cmd_r.sum;
    s1_side_r.neg_x <= s0_cmd_r.dx[DELTA_W-1] ^ num[NUM_W-1];
    s1_side_r.neg_y <= s0_cmd_r.dy[DELTA_W-1] ^ num[NUM_W-1];
    s1_side_r.zero  <= s0_cmd_r.zero;
  end

  // Stage 2: partial products, numerator split in two halves
  logic                   s2_vld_r;
  logic [AD_W+LO_W-1:0]   s2_pl_x_r;
  logic [AD_W+HI_W-1:0]   s2_ph_x_r;
  logic [AD_W+LO_W-1:0]   s2_pl_y_r;
  logic [AD_W+HI_W-1:0]   s2_ph_y_r;
  side_t                  s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_pl_x_r <= s1_ax_r * s1_num_r[LO_W-1:0];
    s2_ph_x_r <= s1_ax_r * s1_num_r[MAG_W-1:LO_W];
    s2_pl_y_r <= s1_ay_r * s1_num_r[LO_W-1:0];
    s2_ph_y_r <= s1_ay_r * s1_num_r[MAG_W-1:LO_W];
    s2_side_r <= s1_side_r;
  end

  // Stage 3: recombine, drop coefficient fraction bits
  logic          s3_vld_r;
  logic [MW-1:0] s3_m_x_r;
  logic [MW-1:0] s3_m_y_r;
  side_t         s3_side_r;
  logic [P_W-1:0] p_x;
  logic [P_W-1:0] p_y;

  assign p_x = P_W'(s2_pl_x_r) + (P_W'(s2_ph_x_r) << LO_W);
  assign p_y = P_W'(s2_pl_y_r) + (P_W'(s2_ph_y_r) << LO_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_m_x_r  <= p_x[P_W-1:COEF_FRAC_BITS];
    s3_m_y_r  <= p_y[P_W-1:COEF_FRAC_BITS];
    s3_side_r <= s2_side_r;
  end

  // Divider entry: flag quotients that cannot fit, then one bit per stage
  div_t          div_r     [QW+1];
  logic          div_vld_r [QW+1];
  logic [MW-1:0] dsor_top;

  assign dsor_top = MW'(s3_side_r.sum) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else begin
      div_vld_r[0] <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    div_r[0].rem_x <= s3_m_x_r;
    div_r[0].rem_y <= s3_m_y_r;
    div_r[0].q_x   <= '0;
    div_r[0].q_y   <= '0;
    div_r[0].sum   <= s3_side_r.sum;
    div_r[0].neg_x <= s3_side_r.neg_x;
    div_r[0].neg_y <= s3_side_r.neg_y;
    div_r[0].ovf_x <= (s3_m_x_r >= dsor_top);
    div_r[0].ovf_y <= (s3_m_y_r >= dsor_top);
    div_r[0].zero  <= s3_side_r.zero;
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int K = QW - j;
    logic [MW-1:0] dsor;
    logic [MW:0]   trial_x;
    logic [MW:0]   trial_y;
    div_t          div_nxt;

    // Restoring step for quotient bit K
    always_comb begin
      div_nxt = div_r[j-1];
      dsor    = MW'(div_r[j-1].sum) << K;
      trial_x = {1'b0, div_r[j-1].rem_x} - {1'b0, dsor};
      trial_y = {1'b0, div_r[j-1].rem_y} - {1'b0, dsor};
      if (!trial_x[MW]) begin
        div_nxt.rem_x  = trial_x[MW-1:0];
        div_nxt.q_x[K] = 1'b1;
      end
      if (!trial_y[MW]) begin
        div_nxt.rem_y  = trial_y[MW-1:0];
        div_nxt.q_y[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[j] <= 1'b0;
      end else begin
        div_vld_r[j] <= div_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      div_r[j] <= div_nxt;
    end
  end

  // Output stage: sign, saturation, zero motion
  logic     out_valid_r;
  pag_out_t out_data_r;
  pag_out_t out_data_nxt;
  logic     sat_x;
  logic     sat_y;

  assign sat_x = div_r[QW].ovf_x | div_r[QW].q_x[QW-1];
  assign sat_y = div_r[QW].ovf_y | div_r[QW].q_y[QW-1];

  always_comb begin
    if (div_r[QW].zero) begin
      out_data_nxt.accel_x = '0;
      out_data_nxt.accel_y = '0;
      out_data_nxt.status  = STATUS_ZERO;
    end else begin
      if (div_r[QW].neg_x) begin
        out_data_nxt.accel_x = sat_x ? OUT_MIN : OUT_W'(-div_r[QW].q_x);
      end else begin
        out_data_nxt.accel_x = sat_x ? OUT_MAX : OUT_W'(div_r[QW].q_x);
      end
      if (div_r[QW].neg_y) begin
        out_data_nxt.accel_y = sat_y ? OUT_MIN : OUT_W'(-div_r[QW].q_y);
      end else begin
        out_data_nxt.accel_y = sat_y ? OUT_MAX : OUT_W'(div_r[QW].q_y);
      end
      out_data_nxt.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PAG_ASSERT_IMP(a_rem_x_bound, div_vld_r[QW] && !div_r[QW].zero && !div_r[QW].ovf_x, div_r[QW].rem_x < MW'(div_r[QW].sum))
  `PAG_ASSERT_IMP(a_rem_y_bound, div_vld_r[QW] && !div_r[QW].zero && !div_r[QW].ovf_y, div_r[QW].rem_y < MW'(div_r[QW].sum))

endmodule

// File: hdl/pointer_accel_gain.sv
// Top level of the piecewise linear pointer acceleration block.
// Depends on pag_pkg, pag_front, pag_queue and pag_back.

// Takes one relative motion word per clock while busy is low and returns one
// result word per input, in order, marked by out_valid for a single cycle.
// Each word passes through the command queue and the 20-stage restoring
// divider in the back end (one quotient bit per stage), plus the lookup,
// multiply and output stages. Every stage advances each cycle, so sustained
// rate is one word per clock; busy rises only if the two-entry command queue
// fills. The receiver cannot stall, so results must be taken in the cycle
// they appear. Configuration writes are always accepted (cfg_ready is high)
// and should only be issued while no word is in flight.
module pointer_accel_gain import pag_pkg::*; #(
  parameter int DELTA_FRAC_BITS = DELTA_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pag_in_t              in_data,
  output logic                 out_valid,
  output pag_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  pag_cmd_t front_cmd;
  pag_cmd_t queue_cmd;
  logic     queue_full;
  logic     queue_pop;
  logic     push;

  assign cfg_ready = 1'b1;
  assign busy      = queue_full;
  assign push      = start && !queue_full;

  // Classify incoming words
  pag_front #(
    .DELTA_FRAC_BITS(DELTA_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (front_cmd)
  );

  // Decouple front and back
  pag_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(front_cmd),
    .full    (queue_full),
    .pop     (queue_pop),
    .pop_cmd (queue_cmd)
  );

  // Gain arithmetic
  pag_back #(
    .DELTA_FRAC_BITS(DELTA_FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (queue_pop),
    .in_cmd   (queue_cmd),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// File: tb/pag_gain_check.sv
`timescale 1ns / 100ps
// Checker for the pointer acceleration block: watches the config, motion and result channels.
// Predicts each result from its own curve table and speed copy; depends on pag_pkg only.
module pag_gain_check import pag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  pag_in_t              in_data,
  input  logic                 out_valid,
  input  pag_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   words_seen,
  output int                   results_checked
);

  localparam int FRAC = 4;   // fraction bits of the motion deltas
  localparam int COEF = 16;  // fraction bits of slopes and offsets

  // Curve constants in hundredths, [level-1][segment]
  int slope_cent [0:10][0:2] = '{
    '{16, 30, 56},   '{32, 60, 112},  '{48, 90, 168},  '{64, 120, 224},
    '{80, 150, 280}, '{86, 195, 364}, '{92, 240, 448}, '{98, 285, 532},
    '{104, 330, 616}, '{110, 375, 700}, '{116, 420, 784}
  };
  int offset_cent [0:10][0:2] = '{
    '{0, -112, -944},    '{0, -224, -1888},   '{0, -336, -2832},
    '{0, -448, -3776},   '{0, -560, -4720},   '{0, -872, -6280},
    '{0, -1184, -7840},  '{0, -1496, -9400},  '{0, -1808, -10960},
    '{0, -2120, -12520}, '{0, -2432, -14080}
  };

  // Speed register copies
  logic [LVL_W-1:0] user_lvl;
  logic             user_lvl_set;
  logic [LVL_W-1:0] vendor_lvl;

  // Results predicted but not yet seen, oldest first
  pag_out_t accel_expected [$];

  // Hundredths to Q.16, nearest with ties away from zero
  function automatic longint cent_to_fixed(input int cent);
    longint mag;
    longint q;
    mag = (cent < 0) ? -longint'(cent) : longint'(cent);
    q = (mag * (longint'(1) << COEF) + 50) / 100;
    return (cent < 0) ? -q : q;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_out(input longint v);
    if (v > OUT_MAX) return OUT_MAX;
    if (v < OUT_MIN) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // Gain applied to one motion word with the current speed setting
  function automatic pag_out_t predict_accel(input pag_in_t w);
    longint dx;
    longint dy;
    longint mag_sum;
    longint num;
    longint den;
    logic [LVL_W-1:0] lvl;
    int seg;
    pag_out_t r;
    dx = longint'($signed(w.delta_x));
    dy = longint'($signed(w.delta_y));
    mag_sum = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
    r.accel_x = '0;
    r.accel_y = '0;
    r.status  = STATUS_ZERO;
    if (mag_sum == 0) return r;
    // user level wins when set or when no vendor level is configured
    lvl = (user_lvl_set || vendor_lvl == 0) ? user_lvl : vendor_lvl;
    if (lvl < LEVEL_MIN) lvl = LEVEL_MIN;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    // mag_sum is twice the speed, so breakpoints scale by 2^(FRAC+1)
    if (mag_sum <= (longint'(BREAK_LOW) << (FRAC + 1))) seg = 0;
    else if (mag_sum <= (longint'(BREAK_MID) << (FRAC + 1))) seg = 1;
    else seg = 2;
    num = cent_to_fixed(slope_cent[lvl-1][seg]) * mag_sum
        + cent_to_fixed(offset_cent[lvl-1][seg]) * (longint'(1) << (FRAC + 1));
    den = (longint'(1) << COEF) * mag_sum;
    r.accel_x = clip_out((dx * num) / den);
    r.accel_y = clip_out((dy * num) / den);
    r.status  = STATUS_OK;
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Track config, queue predictions, compare results
  always @(posedge clk) begin : monitor
    pag_out_t want;
    if (!rst_n) begin
      user_lvl     = USER_SPEED_RST;
      user_lvl_set = 1'b0;
      vendor_lvl   = '0;
      accel_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_USER_SPEED:   user_lvl = cfg_data;
          CFG_USER_SET:     user_lvl_set = cfg_data[0];
          CFG_VENDOR_SPEED: vendor_lvl = cfg_data;
          default: ;  // unmapped index, dropped
        endcase
      end
      if (start && !busy) begin
        accel_expected.push_back(predict_accel(in_data));
        words_seen++;
      end
      if (out_valid) begin
        if (accel_expected.size() == 0) begin
          $error("result word with nothing expected: x=%0d y=%0d status=%0d",
                 $signed(out_data.accel_x), $signed(out_data.accel_y), out_data.status);
          fail_count++;
        end else begin
          want = accel_expected.pop_front();
          check_field("accel_x", $signed(want.accel_x), $signed(out_data.accel_x));
          check_field("accel_y", $signed(want.accel_y), $signed(out_data.accel_y));
          check_field("status", want.status, out_data.status);
          results_checked++;
        end
      end
    end
    pending = accel_expected.size();
  end

endmodule

// File: tb/pointer_accel_gain_tb.sv
`timescale 1ns / 100ps
// Top of the pointer acceleration testbench: clock, reset, motion and speed stimulus, verdict.
// Depends on pag_pkg, pointer_accel_gain and pag_gain_check.
module pointer_accel_gain_tb;
  import pag_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 40;   // idle wait after the last result, before the verdict
  localparam int WORDS_PER_PHASE = 50;
  localparam int FIXED_PHASES    = 8;
  localparam int RANDOM_PHASES   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  pag_in_t              in_data = '0;
  logic                 out_valid;
  pag_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_USER_SPEED;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int words_seen;
  int results_checked;
  int cycle_count;

  // Directed motion: zero, unit steps, segment edges, full-scale corners
  int dir_x [20] = '{0, 1, 0, -1, 256, 128, -1024, 0, 600, 32767,
                     -32768, 32767, -32768, 0, 16, 3, 21845, -7, 5000, -1};
  int dir_y [20] = '{0, 0, -1, 1, 0, 129, 0, 1025, -424, 32767,
                     -32768, -32768, 0, 32767, 16, -5, -10922, 0, 0, -1};

  // Speed settings per phase: user level, user override, vendor level
  logic [3:0] ph_user   [FIXED_PHASES] = '{1, 11, 3, 0, 15, 6, 8, 2};
  logic       ph_set    [FIXED_PHASES] = '{0, 1, 0, 1, 0, 0, 0, 1};
  logic [3:0] ph_vendor [FIXED_PHASES] = '{0, 7, 11, 9, 0, 15, 1, 12};

  int corner_vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
  int seg_bounds  [6] = '{255, 256, 257, 1023, 1024, 1025};

  always #2 clk = ~clk;

  pointer_accel_gain dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pag_gain_check gain_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .words_seen      (words_seen),
    .results_checked (results_checked)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Random motion word, weighted toward segment edges and small moves
  function automatic pag_in_t random_motion();
    int a;
    int b;
    int total;
    int pick;
    pag_in_t w;
    pick = $urandom_range(99);
    if (pick < 20) begin
      a = int'($urandom_range(64)) - 32;
      b = int'($urandom_range(64)) - 32;
    end else if (pick < 45) begin
      // |dx| + |dy| on or next to a breakpoint
      total = seg_bounds[$urandom_range(5)];
      a = $urandom_range(total);
      b = total - a;
      if ($urandom_range(1)) a = -a;
      if ($urandom_range(1)) b = -b;
    end else if (pick < 70) begin
      a = int'($urandom_range(4096)) - 2048;
      b = int'($urandom_range(4096)) - 2048;
    end else if (pick < 90) begin
      a = $urandom_range(65535);
      b = $urandom_range(65535);
    end else begin
      a = corner_vals[$urandom_range(5)];
      b = corner_vals[$urandom_range(5)];
    end
    w.delta_x = a[DELTA_W-1:0];
    w.delta_y = b[DELTA_W-1:0];
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // busy only moves at a rising edge, so its value here holds for the next one.
  task automatic put_word(input pag_in_t w, input int idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data = w;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    start = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic apply_speeds(input logic [3:0] user, input logic set,
                              input logic [3:0] vendor);
    logic [2:0] junk;
    junk = 3'($urandom_range(7));
    settle();
    write_reg(CFG_USER_SPEED, user);
    write_reg(CFG_USER_SET, {junk, set});  // only bit 0 matters
    write_reg(CFG_VENDOR_SPEED, vendor);
    write_reg(CFG_UNUSED, CFG_DAT_W'($urandom_range(15)));
  endtask

  initial begin
    int idle_pct;
    pag_in_t w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words at reset speed settings
    foreach (dir_x[i]) begin
      w.delta_x = dir_x[i][DELTA_W-1:0];
      w.delta_y = dir_y[i][DELTA_W-1:0];
      put_word(w, 0);
    end

    // Random phases: fixed corner settings, then random ones
    for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
      if (p < FIXED_PHASES)
        apply_speeds(ph_user[p], ph_set[p], ph_vendor[p]);
      else
        apply_speeds(4'($urandom_range(15)), 1'($urandom_range(1)),
                     4'($urandom_range(15)));
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 75;
        default: idle_pct = 21;
      endcase
      repeat (WORDS_PER_PHASE) put_word(random_motion(), idle_pct);
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d motion words over %0d speed settings, back to back and with idle gaps",
             words_seen, FIXED_PHASES + RANDOM_PHASES + 1);
    $display("%0d results compared, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/pag_pkg.sv
hdl/pag_front.sv
hdl/pag_queue.sv
hdl/pag_back.sv
hdl/pointer_accel_gain.sv
tb/pag_gain_check.sv
tb/pointer_accel_gain_tb.sv
